### src/spvc_pkg.sv
// ============================================================================
// spvc_pkg - shared constants and types of the six-axis PID velocity controller
// Field widths, tuning word layout and the pipeline control bundle.
// ============================================================================
`default_nettype none

package spvc_pkg;

    // Number of lanes that the word carries (one per axis field)
    localparam int NUM_LANES = 6;

    // Defaults of the top-level parameters
    localparam int AXES_DEF  = 6;
    localparam int INT_W_DEF = 32;

    // Payload widths
    localparam int VEL_W     = 16;
    localparam int THR_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int FRAC_BITS = 8;

    // Configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Register index of the first tuning word; axis k sits at base + k
    localparam int REG_AXIS_TUNING_BASE = 0;

    // Tuning word layout
    localparam int SP_LSB = 0;
    localparam int KP_LSB = 16;
    localparam int KI_LSB = 32;
    localparam int KD_LSB = 48;

    // Product widths that do not depend on the integral width
    localparam int PROD_P_W = GAIN_W + VEL_W;
    localparam int PROD_D_W = GAIN_W + VEL_W + 1;

    typedef struct packed {
        logic acc;   // input word accepted this cycle
        logic en1;   // first stage may load
        logic en2;   // product stage may load
        logic en3;   // output register may load
        logic v2;    // product stage holds a valid word
    } t_pipe_ctl;

endpackage

`default_nettype wire

### src/spvc_vel_if.sv
// ============================================================================
// spvc_vel_if - velocity channel
// Valid/ready channel carrying one measured velocity per axis.
// ============================================================================
`default_nettype none

interface spvc_vel_if;
    import spvc_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [VEL_W-1:0] velocity_0;
    logic signed [VEL_W-1:0] velocity_1;
    logic signed [VEL_W-1:0] velocity_2;
    logic signed [VEL_W-1:0] velocity_3;
    logic signed [VEL_W-1:0] velocity_4;
    logic signed [VEL_W-1:0] velocity_5;

    modport source (
        output valid, velocity_0, velocity_1, velocity_2,
               velocity_3, velocity_4, velocity_5,
        input  ready
    );

    modport sink (
        input  valid, velocity_0, velocity_1, velocity_2,
               velocity_3, velocity_4, velocity_5,
        output ready
    );
endinterface

`default_nettype wire

### src/spvc_thr_if.sv
// ============================================================================
// spvc_thr_if - thrust channel
// Valid/ready channel carrying one saturated thrust per axis.
// ============================================================================
`default_nettype none

interface spvc_thr_if;
    import spvc_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [THR_W-1:0] thrust_0;
    logic signed [THR_W-1:0] thrust_1;
    logic signed [THR_W-1:0] thrust_2;
    logic signed [THR_W-1:0] thrust_3;
    logic signed [THR_W-1:0] thrust_4;
    logic signed [THR_W-1:0] thrust_5;

    modport source (
        output valid, thrust_0, thrust_1, thrust_2,
               thrust_3, thrust_4, thrust_5,
        input  ready
    );

    modport sink (
        input  valid, thrust_0, thrust_1, thrust_2,
               thrust_3, thrust_4, thrust_5,
        output ready
    );
endinterface

`default_nettype wire

### src/spvc_lane.sv
// ============================================================================
// spvc_lane - one PID axis lane
// Error, saturating integral and difference on accept; three gain products
// in the following stage.
// ============================================================================
`default_nettype none

module spvc_lane #(
    parameter int INT_W = spvc_pkg::INT_W_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire spvc_pkg::t_pipe_ctl                    i_ctl,
    input  wire logic [spvc_pkg::CFG_W-1:0]             i_tuning,
    input  wire logic signed [spvc_pkg::VEL_W-1:0]      i_velocity,
    output logic signed [spvc_pkg::PROD_P_W-1:0]        o_prod_p,
    output logic signed [INT_W+spvc_pkg::GAIN_W-1:0]    o_prod_i,
    output logic signed [spvc_pkg::PROD_D_W-1:0]        o_prod_d
);
    import spvc_pkg::*;

    logic signed [GAIN_W-1:0] w_sp;
    logic signed [GAIN_W-1:0] w_kp;
    logic signed [GAIN_W-1:0] w_ki;
    logic signed [GAIN_W-1:0] w_kd;

    logic [VEL_W:0]           w_err_full;
    logic signed [VEL_W-1:0]  w_err;
    logic [INT_W:0]           w_int_full;
    logic signed [INT_W-1:0]  w_int_new;
    logic signed [VEL_W:0]    w_diff;

    // State doubles as the first stage: it holds this word's error and
    // integral until the next accept, which moves the stage on at once.
    logic signed [INT_W-1:0]  r_int_sum;
    logic signed [VEL_W-1:0]  r_prev_err;
    logic signed [VEL_W:0]    r_diff;

    logic signed [PROD_P_W-1:0]     r_prod_p;
    logic signed [INT_W+GAIN_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0]     r_prod_d;

    assign w_sp = i_tuning[SP_LSB +: GAIN_W];
    assign w_kp = i_tuning[KP_LSB +: GAIN_W];
    assign w_ki = i_tuning[KI_LSB +: GAIN_W];
    assign w_kd = i_tuning[KD_LSB +: GAIN_W];

    always_comb begin
        w_err_full = {w_sp[GAIN_W-1], w_sp} - {i_velocity[VEL_W-1], i_velocity};
        // clamp to 16 bits when the two top bits disagree
        if (w_err_full[VEL_W] != w_err_full[VEL_W-1]) begin
            w_err = {w_err_full[VEL_W], {(VEL_W-1){~w_err_full[VEL_W]}}};
        end else begin
            w_err = w_err_full[VEL_W-1:0];
        end

        w_int_full = {r_int_sum[INT_W-1], r_int_sum}
                   + {{(INT_W+1-VEL_W){w_err[VEL_W-1]}}, w_err};
        if (w_int_full[INT_W] != w_int_full[INT_W-1]) begin
            w_int_new = {w_int_full[INT_W], {(INT_W-1){~w_int_full[INT_W]}}};
        end else begin
            w_int_new = w_int_full[INT_W-1:0];
        end

        w_diff = {w_err[VEL_W-1], w_err} - {r_prev_err[VEL_W-1], r_prev_err};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_sum  <= '0;
            r_prev_err <= '0;
        end else if (i_ctl.acc) begin
            r_int_sum  <= w_int_new;
            r_prev_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_diff <= w_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_prod_p <= PROD_P_W'(w_kp) * PROD_P_W'(r_prev_err);
            r_prod_i <= (INT_W+GAIN_W)'(w_ki) * (INT_W+GAIN_W)'(r_int_sum);
            r_prod_d <= PROD_D_W'(w_kd) * PROD_D_W'(r_diff);
        end
    end

    assign o_prod_p = r_prod_p;
    assign o_prod_i = r_prod_i;
    assign o_prod_d = r_prod_d;

endmodule

`default_nettype wire

### src/spvc_merge.sv
// ============================================================================
// spvc_merge - lane merge and output register
// Sums each lane's products, scales, saturates to 24 bits and registers the
// thrust word.
// ============================================================================
`default_nettype none

module spvc_merge #(
    parameter int INT_W = spvc_pkg::INT_W_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire spvc_pkg::t_pipe_ctl                  i_ctl,
    input  wire logic signed [spvc_pkg::PROD_P_W-1:0] i_prod_p [spvc_pkg::NUM_LANES],
    input  wire logic signed [INT_W+spvc_pkg::GAIN_W-1:0]
                                                      i_prod_i [spvc_pkg::NUM_LANES],
    input  wire logic signed [spvc_pkg::PROD_D_W-1:0] i_prod_d [spvc_pkg::NUM_LANES],
    output logic                                      o_valid,
    output logic signed [spvc_pkg::THR_W-1:0]         o_thrust [spvc_pkg::NUM_LANES]
);
    import spvc_pkg::*;

    localparam int ACC_W = INT_W + GAIN_W + 2;

    logic                    r_valid;
    logic signed [THR_W-1:0] r_thrust [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en3) begin
            r_valid <= i_ctl.v2;
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        logic signed [ACC_W-1:0] w_sum;
        logic signed [ACC_W-1:0] w_sh;
        logic                    w_fits;

        always_comb begin
            w_sum  = ACC_W'(i_prod_p[k]) + ACC_W'(i_prod_i[k]) + ACC_W'(i_prod_d[k]);
            w_sh   = w_sum >>> FRAC_BITS;
            w_fits = (&w_sh[ACC_W-1:THR_W-1]) | ~(|w_sh[ACC_W-1:THR_W-1]);
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en3) begin
                r_thrust[k] <= w_fits ? w_sh[THR_W-1:0]
                                      : {w_sh[ACC_W-1], {(THR_W-1){~w_sh[ACC_W-1]}}};
            end
        end

        assign o_thrust[k] = r_thrust[k];
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

### src/six_axis_pid_velocity_controller.sv
// ============================================================================
// six_axis_pid_velocity_controller - per-axis discrete PID on velocity words
// Six parallel PID lanes behind one valid/ready channel, merged into one
// saturated thrust word per accepted velocity word.
// ============================================================================
// An accepted velocity word passes the lane update, the gain products and the
//   sum/scale/saturate register before its thrust word is on the output.
// Throughput: one word per cycle; the lanes and the three-stage pipe take a
//   new word every cycle as long as the output side drains.
// Reset: synchronous, active low; clears tuning words, integrals, previous
//   errors and all valid flags. No clearing pass is needed.
`default_nettype none

module six_axis_pid_velocity_controller #(
    parameter int AXES           = spvc_pkg::AXES_DEF,
    parameter int INTEGRAL_WIDTH = spvc_pkg::INT_W_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [spvc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [spvc_pkg::CFG_W-1:0]      i_cfg_data,
    spvc_vel_if.sink                             i_vel,
    spvc_thr_if.source                           o_thr
);
    import spvc_pkg::*;

    // ------------------------------------------------------------------
    // Tuning registers: one packed setpoint/kp/ki/kd word per axis.
    // Writes to an index past the last axis word are dropped.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_tune [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_tune[k] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(REG_AXIS_TUNING_BASE + k)) begin
                    r_tune[k] <= i_cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipe control. Each stage loads when it is empty or when the stage
    // after it moves on, so a bubble is squeezed out and the input keeps
    // flowing into empty stages while a finished word waits at the output.
    // ------------------------------------------------------------------
    t_pipe_ctl w_ctl;
    logic      r_v1;
    logic      r_v2;
    logic      w_out_valid;

    always_comb begin
        w_ctl.en3 = !w_out_valid || o_thr.ready;
        w_ctl.en2 = !r_v2 || w_ctl.en3;
        w_ctl.en1 = !r_v1 || w_ctl.en2;
        w_ctl.acc = w_ctl.en1 && i_vel.valid;
        w_ctl.v2  = r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_ctl.en1) begin
                r_v1 <= i_vel.valid;
            end
            if (w_ctl.en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    assign i_vel.ready = w_ctl.en1;

    // ------------------------------------------------------------------
    // Unpack the velocity word into lanes.
    // ------------------------------------------------------------------
    logic signed [VEL_W-1:0] w_vel [NUM_LANES];

    assign w_vel[0] = i_vel.velocity_0;
    assign w_vel[1] = i_vel.velocity_1;
    assign w_vel[2] = i_vel.velocity_2;
    assign w_vel[3] = i_vel.velocity_3;
    assign w_vel[4] = i_vel.velocity_4;
    assign w_vel[5] = i_vel.velocity_5;

    // ------------------------------------------------------------------
    // Lanes. Axes at or past AXES have no lane; their products are held
    // at zero, so the merge writes a zero thrust for them.
    // ------------------------------------------------------------------
    logic signed [PROD_P_W-1:0]              w_prod_p [NUM_LANES];
    logic signed [INTEGRAL_WIDTH+GAIN_W-1:0] w_prod_i [NUM_LANES];
    logic signed [PROD_D_W-1:0]              w_prod_d [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_axis
        if (k < AXES) begin : g_on
            spvc_lane #(
                .INT_W (INTEGRAL_WIDTH)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_tuning   (r_tune[k]),
                .i_velocity (w_vel[k]),
                .o_prod_p   (w_prod_p[k]),
                .o_prod_i   (w_prod_i[k]),
                .o_prod_d   (w_prod_d[k])
            );
        end else begin : g_off
            assign w_prod_p[k] = '0;
            assign w_prod_i[k] = '0;
            assign w_prod_d[k] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Merge: sum, scale by 2^-8 (floor), saturate, register.
    // ------------------------------------------------------------------
    logic signed [THR_W-1:0] w_thrust [NUM_LANES];

    spvc_merge #(
        .INT_W (INTEGRAL_WIDTH)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_prod_p (w_prod_p),
        .i_prod_i (w_prod_i),
        .i_prod_d (w_prod_d),
        .o_valid  (w_out_valid),
        .o_thrust (w_thrust)
    );

    assign o_thr.valid    = w_out_valid;
    assign o_thr.thrust_0 = w_thrust[0];
    assign o_thr.thrust_1 = w_thrust[1];
    assign o_thr.thrust_2 = w_thrust[2];
    assign o_thr.thrust_3 = w_thrust[3];
    assign o_thr.thrust_4 = w_thrust[4];
    assign o_thr.thrust_5 = w_thrust[5];

endmodule

`default_nettype wire

### src/spvc_checker.sv
// ============================================================================
// spvc_checker - port-level checks of the PID velocity controller
// Reset, flow and latency properties seen on the top-level channels.
// ============================================================================
`default_nettype none

module spvc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [spvc_pkg::THR_W-1:0]     i_thrust_0
);
    import spvc_pkg::*;

    // no word leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("thrust word valid right after reset");

    // an empty output stage never blocks the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // an accepted word reaches the output through the product and output registers when the output drains
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("thrust word missing three cycles after accept");

    // a stalled thrust word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_thrust_0))
        else $error("stalled thrust word changed");

endmodule

bind six_axis_pid_velocity_controller spvc_checker u_spvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vel.valid),
    .i_in_ready  (i_vel.ready),
    .i_out_valid (o_thr.valid),
    .i_out_ready (o_thr.ready),
    .i_thrust_0  (o_thr.thrust_0)
);

`default_nettype wire
